// ===== sv/pef_pkg.sv =====
package pef_pkg;

	localparam int PIX_W   = 16;
	localparam int COORD_W = 16;
	localparam int APB_AW  = 6;
	localparam int APB_DW  = 64;

	typedef enum logic [2:0] {
		REG_FILL_COLOR,
		REG_VERTEX_COUNT,
		REG_IMAGE_WIDTH,
		REG_KEEP_PIXEL_RGB,
		REG_KEEP_PIXEL_ALPHA,
		REG_SQUARED_EDGE_ARC,
		REG_ALPHA_SHIFTS_X
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] fill_color;
		logic [4:0]  vertex_count;
		logic [15:0] image_width;
		logic        keep_pixel_rgb;
		logic        keep_pixel_alpha;
		logic        squared_edge_arc;
		logic        alpha_shifts_x;
	} cfg_t;

endpackage

// ===== sv/pef_item_if.sv =====
interface pef_item_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [3:0]                        vertex_index;
	logic signed [pef_pkg::COORD_W-1:0] vertex_x;
	logic signed [pef_pkg::COORD_W-1:0] vertex_y;
	logic [pef_pkg::PIX_W-1:0]         pixel_red;
	logic [pef_pkg::PIX_W-1:0]         pixel_green;
	logic [pef_pkg::PIX_W-1:0]         pixel_blue;
	logic [pef_pkg::PIX_W-1:0]         pixel_alpha;

	modport source (
		output valid, req_type, vertex_index, vertex_x, vertex_y,
		output pixel_red, pixel_green, pixel_blue, pixel_alpha,
		input  ready
	);
	modport sink (
		input  valid, req_type, vertex_index, vertex_x, vertex_y,
		input  pixel_red, pixel_green, pixel_blue, pixel_alpha,
		output ready
	);
endinterface

// ===== sv/pef_result_if.sv =====
interface pef_result_if;
	logic                      valid;
	logic                      ready;
	logic [pef_pkg::PIX_W-1:0] out_red;
	logic [pef_pkg::PIX_W-1:0] out_green;
	logic [pef_pkg::PIX_W-1:0] out_blue;
	logic [pef_pkg::PIX_W-1:0] out_alpha;
	logic                      inside_res;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha, inside_res,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha, inside_res,
		output ready
	);
endinterface

// ===== sv/pef_cfg.sv =====
module pef_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pef_pkg::APB_AW-1:0] paddr,
	input  logic [pef_pkg::APB_DW-1:0] pwdata,
	output logic [pef_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output pef_pkg::cfg_t              cfg
);

	pef_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	assign reg_idx = pef_pkg::reg_idx_t'(paddr[pef_pkg::APB_AW-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.fill_color       <= '0;
			cfg.vertex_count     <= 5'd3;
			cfg.image_width      <= 16'd1;
			cfg.keep_pixel_rgb   <= 1'b0;
			cfg.keep_pixel_alpha <= 1'b0;
			cfg.squared_edge_arc <= 1'b0;
			cfg.alpha_shifts_x   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				pef_pkg::REG_FILL_COLOR:       cfg.fill_color       <= pwdata;
				pef_pkg::REG_VERTEX_COUNT:     cfg.vertex_count     <= pwdata[4:0];
				pef_pkg::REG_IMAGE_WIDTH:      cfg.image_width      <= pwdata[15:0];
				pef_pkg::REG_KEEP_PIXEL_RGB:   cfg.keep_pixel_rgb   <= pwdata[0];
				pef_pkg::REG_KEEP_PIXEL_ALPHA: cfg.keep_pixel_alpha <= pwdata[0];
				pef_pkg::REG_SQUARED_EDGE_ARC: cfg.squared_edge_arc <= pwdata[0];
				pef_pkg::REG_ALPHA_SHIFTS_X:   cfg.alpha_shifts_x   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			pef_pkg::REG_FILL_COLOR:       prdata = cfg.fill_color;
			pef_pkg::REG_VERTEX_COUNT:     prdata = pef_pkg::APB_DW'(cfg.vertex_count);
			pef_pkg::REG_IMAGE_WIDTH:      prdata = pef_pkg::APB_DW'(cfg.image_width);
			pef_pkg::REG_KEEP_PIXEL_RGB:   prdata = pef_pkg::APB_DW'(cfg.keep_pixel_rgb);
			pef_pkg::REG_KEEP_PIXEL_ALPHA: prdata = pef_pkg::APB_DW'(cfg.keep_pixel_alpha);
			pef_pkg::REG_SQUARED_EDGE_ARC: prdata = pef_pkg::APB_DW'(cfg.squared_edge_arc);
			pef_pkg::REG_ALPHA_SHIFTS_X:   prdata = pef_pkg::APB_DW'(cfg.alpha_shifts_x);
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== sv/pef_corner_ram.sv =====
module pef_corner_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 wa,
	input  logic [2*pef_pkg::COORD_W-1:0] wd,
	input  logic [AW-1:0]                 ra0,
	input  logic [AW-1:0]                 ra1,
	output logic [2*pef_pkg::COORD_W-1:0] rd0,
	output logic [2*pef_pkg::COORD_W-1:0] rd1
);

	logic [2*pef_pkg::COORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end

endmodule

// ===== sv/polygon_even_odd_fill.sv =====
// Even-odd polygon fill over a raster pixel stream.
// Channel item (valid/ready): req_type 0 writes one polygon corner into slot
// vertex_index and rewinds the raster position to column 0, row 0; no result.
// req_type 1 is the next pixel in raster order; it yields one result on
// channel result: inside, fill color (RGB kept if keep_pixel_rgb, alpha if
// keep_pixel_alpha), else the pixel unchanged; inside_res gives the test.
// Configuration goes through the APB port, 64-bit registers at 8*index.
// A pixel passes a shift step, then per edge a corner read and a set-up
// with the half-open y span test; an edge whose y span holds the pixel row
// also runs its multiply steps and a finish step that updates the parity.
// The result is registered once the last edge is through these steps.
// Every edge is walked in turn; spanning edges go through one 36x17
// multiplier and one accumulator: two partial products per spanning edge,
// or two squarings and four partial products in arc mode. The result register sits
// after the block: the next item is taken while a result waits, but a finished
// pixel holds in the block until the previous result is taken. Reset clears
// state, configuration and raster position; the corner table holds no reset
// value and must be loaded.
module polygon_even_odd_fill #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pef_item_if.sink                   item,
	pef_result_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pef_pkg::APB_AW-1:0] paddr,
	input  logic [pef_pkg::APB_DW-1:0] pwdata,
	output logic [pef_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int IW     = $clog2(MAX_VERTICES);
	localparam int NW     = (IW + 1 > 5) ? IW + 1 : 5;
	localparam int CW     = pef_pkg::COORD_W;
	localparam int LW     = 36;
	localparam int BW     = 16;
	localparam int PW     = LW + BW + 1;
	localparam int AW     = 68;
	localparam int SW     = 33;
	localparam int DEN_SH = 17;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SHIFT, ST_RD, ST_SET, ST_SQQ, ST_SQP,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_FIN, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		TG_NONE, TG_SHIFT, TG_Q, TG_P, TG_ADD0, TG_ADD16, TG_SUB0, TG_SUB16
	} tag_t;

	pef_pkg::cfg_t cfg;

	pef_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	state_t state_q;
	tag_t   tag_q, tag_d;
	logic [IW-1:0] edge_q;
	logic          parity_q;
	logic [14:0]   col_q, row_q;
	logic          out_valid_q;

	logic [pef_pkg::PIX_W-1:0] pix_r_q, pix_g_q, pix_b_q, pix_a_q;
	logic [pef_pkg::PIX_W-1:0] out_r_q, out_g_q, out_b_q, out_a_q;
	logic                      out_in_q;

	logic signed [PW-1:0] prod_q, mul_p;
	logic signed [LW-1:0] mul_a, lhs_q, rhs_q;
	logic [BW-1:0]        mul_b;
	logic [31:0]          p_q, q_q;
	logic signed [AW-1:0] acc_q, acc_next, add_ext, add_sh;
	logic signed [SW-1:0] shift_q;

	logic item_acc, vtx_wr, finish, last_edge, span;
	logic [NW-1:0] n_eff;
	logic [IW-1:0] nxt_idx;
	logic [15:0]   w_eff, col_inc;
	logic [2*CW-1:0] rd0, rd1;
	logic signed [17:0] alpha_term;

	logic signed [CW:0]   x0, y0, x1, y1, yv;
	logic signed [17:0]   dx, dy;
	logic signed [CW:0]   ex, dq;
	logic signed [LW-1:0] dx_l, ex_l;
	logic [15:0]          p_new, q_new;

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign vtx_wr     = item_acc && !item.req_type && (32'(item.vertex_index) < MAX_VERTICES);
	assign finish     = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign n_eff = (32'(cfg.vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
	                                                       : NW'(cfg.vertex_count);
	assign last_edge = (NW'(edge_q) + NW'(1)) == n_eff;
	assign nxt_idx   = last_edge ? '0 : edge_q + IW'(1);

	assign w_eff = (cfg.image_width == 16'd0)     ? 16'd1 :
	               (cfg.image_width > 16'd32768)  ? 16'd32768 : cfg.image_width;
	assign col_inc = {1'b0, col_q} + 16'd1;

	pef_corner_ram #(.DEPTH(MAX_VERTICES), .AW(IW)) u_ram (
		.clk(clk),
		.we (vtx_wr),
		.wa (IW'(item.vertex_index)),
		.wd ({item.vertex_x, item.vertex_y}),
		.ra0(edge_q),
		.ra1(nxt_idx),
		.rd0(rd0),
		.rd1(rd1)
	);

	// edge setup: half-open span test and the exact crossing operands
	always_comb begin
		x0 = (CW+1)'($signed(rd0[2*CW-1:CW]));
		y0 = (CW+1)'($signed(rd0[CW-1:0]));
		x1 = (CW+1)'($signed(rd1[2*CW-1:CW]));
		y1 = (CW+1)'($signed(rd1[CW-1:0]));
		yv = $signed({2'b00, row_q});
		span = ((y0 <= yv) && (y1 > yv)) || ((y0 > yv) && (y1 <= yv));
		dx = $signed({3'b000, col_q}) - 18'(x0);
		ex = x1 - x0;
		dy = 18'(yv) - 18'(y0);
		dq = y1 - y0;
		dx_l = LW'(dx);
		ex_l = LW'(ex);
		// orient the edge so the denominator is positive
		if (dq[CW]) begin
			p_new = 16'(-dy);
			q_new = 16'(-dq);
		end else begin
			p_new = 16'(dy);
			q_new = 16'(dq);
		end
	end

	assign alpha_term = $signed({1'b0, pix_a_q, 1'b0}) - 18'sd65535;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		tag_d = TG_NONE;
		unique case (state_q)
			ST_SHIFT: begin
				mul_a = cfg.alpha_shifts_x ? LW'(alpha_term) : '0;
				mul_b = w_eff;
				tag_d = TG_SHIFT;
			end
			ST_SQQ: begin
				mul_a = $signed(LW'(q_q[BW-1:0]));
				mul_b = q_q[BW-1:0];
				tag_d = TG_Q;
			end
			ST_SQP: begin
				mul_a = $signed(LW'(p_q[BW-1:0]));
				mul_b = p_q[BW-1:0];
				tag_d = TG_P;
			end
			ST_M0: begin
				mul_a = lhs_q;
				mul_b = q_q[BW-1:0];
				tag_d = TG_ADD0;
			end
			ST_M1: begin
				mul_a = lhs_q;
				mul_b = q_q[31:BW];
				tag_d = TG_ADD16;
			end
			ST_M2: begin
				mul_a = rhs_q;
				mul_b = p_q[BW-1:0];
				tag_d = TG_SUB0;
			end
			ST_M3: begin
				mul_a = rhs_q;
				mul_b = p_q[31:BW];
				tag_d = TG_SUB16;
			end
			default: ;
		endcase
	end

	assign mul_p   = mul_a * $signed({1'b0, mul_b});
	assign add_ext = AW'(prod_q);
	assign add_sh  = (tag_q == TG_ADD16 || tag_q == TG_SUB16) ? (add_ext <<< BW) : add_ext;
	assign acc_next = (tag_q == TG_SUB0 || tag_q == TG_SUB16) ? acc_q - add_sh
	                                                          : acc_q + add_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tag_q       <= TG_NONE;
			edge_q      <= '0;
			parity_q    <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_q <= tag_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.req_type) begin
							state_q  <= ST_SHIFT;
							edge_q   <= '0;
							parity_q <= 1'b0;
						end else begin
							col_q <= '0;
							row_q <= '0;
						end
					end
				end
				ST_SHIFT: state_q <= (n_eff == '0) ? ST_DONE : ST_RD;
				ST_RD:    state_q <= ST_SET;
				ST_SET: begin
					if (!span) begin
						state_q <= last_edge ? ST_DONE : ST_RD;
						edge_q  <= nxt_idx;
					end else begin
						state_q <= cfg.squared_edge_arc ? ST_SQQ : ST_M0;
					end
				end
				ST_SQQ: state_q <= ST_SQP;
				ST_SQP: state_q <= ST_M0;
				ST_M0:  state_q <= cfg.squared_edge_arc ? ST_M1 : ST_M2;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= cfg.squared_edge_arc ? ST_M3 : ST_FIN;
				ST_M3:  state_q <= ST_FIN;
				ST_FIN: begin
					// negative difference means the tested x is left of the crossing
					parity_q <= parity_q ^ acc_next[AW-1];
					state_q  <= last_edge ? ST_DONE : ST_RD;
					edge_q   <= nxt_idx;
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (col_inc >= w_eff) begin
							col_q <= '0;
							row_q <= row_q + 15'd1;
						end else begin
							col_q <= col_inc[14:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (item_acc && item.req_type) begin
			pix_r_q <= item.pixel_red;
			pix_g_q <= item.pixel_green;
			pix_b_q <= item.pixel_blue;
			pix_a_q <= item.pixel_alpha;
		end
		if (tag_q == TG_SHIFT) begin
			shift_q <= prod_q[SW-1:0];
		end
		if (state_q == ST_SET) begin
			// times 131070 as (v << 17) - (v << 1)
			lhs_q <= (dx_l <<< DEN_SH) - (dx_l <<< 1) + LW'(shift_q);
			rhs_q <= (ex_l <<< DEN_SH) - (ex_l <<< 1);
			p_q   <= 32'(p_new);
			q_q   <= 32'(q_new);
			acc_q <= '0;
		end else begin
			if (tag_q == TG_P) begin
				p_q <= prod_q[31:0];
			end
			if (tag_q == TG_Q) begin
				q_q <= prod_q[31:0];
			end
			if (tag_q == TG_ADD0 || tag_q == TG_ADD16 || tag_q == TG_SUB0 ||
			    tag_q == TG_SUB16) begin
				acc_q <= acc_next;
			end
		end
		if (finish) begin
			out_in_q <= parity_q;
			out_r_q  <= (parity_q && !cfg.keep_pixel_rgb) ? cfg.fill_color[63:48] : pix_r_q;
			out_g_q  <= (parity_q && !cfg.keep_pixel_rgb) ? cfg.fill_color[47:32] : pix_g_q;
			out_b_q  <= (parity_q && !cfg.keep_pixel_rgb) ? cfg.fill_color[31:16] : pix_b_q;
			out_a_q  <= (parity_q && !cfg.keep_pixel_alpha) ? cfg.fill_color[15:0] : pix_a_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_red    = out_r_q;
	assign result.out_green  = out_g_q;
	assign result.out_blue   = out_b_q;
	assign result.out_alpha  = out_a_q;
	assign result.inside_res = out_in_q;

`ifndef SYNTH
	a_edge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_SET || state_q == ST_FIN) |->
		(NW'(edge_q) < n_eff))
		else $error("edge index beyond vertex count");

	a_square_only_arc: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_q == TG_P || tag_q == TG_Q) |-> cfg.squared_edge_arc)
		else $error("squaring step outside arc mode");

	a_vertex_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && !item.req_type) |=> (col_q == '0 && row_q == '0))
		else $error("corner load did not rewind raster");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.req_type) |=> !$rose(result.valid))
		else $error("result appeared too early");

	a_pixel_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && finish) |=> (result.valid && state_q == ST_IDLE))
		else $error("finished pixel not presented");
`endif

endmodule
